// ===== sv/p2m_pkg.sv =====
// Shared types, widths and constants for the PHA to MIP calibration block.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package p2m_pkg;

	// Widths of the sample and of the calibration registers.
	localparam int PHA_BITS      = 12;
	localparam int MIP_FRAC_BITS = 8;
	localparam int CFG_W         = 16;
	localparam int CFG_FRAC      = 4;
	localparam int OUT_W         = 19;

	// Pulse scaled to register units, signed difference magnitude width.
	localparam int P_W   = PHA_BITS + CFG_FRAC;
	localparam int D_W   = (P_W > CFG_W) ? P_W : CFG_W;
	// Divider widths: divisor is a 16x16 product, dividend carries the fraction.
	localparam int DEN_W = 2 * CFG_W;
	localparam int NUM_W = DEN_W + MIP_FRAC_BITS;
	localparam int REM_W = DEN_W;

	// Stream word widths, rounded up to whole bytes.
	localparam int IN_TDATA_W  = ((PHA_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	// Configuration port.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_PED_LOW  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIP_PEAK = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PED_HIGH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLOPE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SAT      = 3'd4;

	// Calibration constants.
	localparam int FLOOR_MIP  = 5;
	localparam int CEIL_MIP   = 1000;
	localparam int SAT_MARGIN = 50 << CFG_FRAC;

	localparam longint OUT_MAX_L   = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint FLOOR_RAW   = longint'(FLOOR_MIP) << MIP_FRAC_BITS;
	localparam longint CEIL_RAW    = longint'(CEIL_MIP) << MIP_FRAC_BITS;
	localparam longint FLOOR_SAT_L = (FLOOR_RAW > OUT_MAX_L) ? OUT_MAX_L : FLOOR_RAW;
	localparam longint CEIL_SAT_L  = (CEIL_RAW > OUT_MAX_L) ? OUT_MAX_L : CEIL_RAW;

	localparam logic [OUT_W-1:0] OUT_MAX   = OUT_W'(OUT_MAX_L);
	localparam logic [OUT_W-1:0] OUT_MIN   = OUT_W'(OUT_MAX_L + 1);
	localparam logic [OUT_W-1:0] FLOOR_VAL = OUT_W'(FLOOR_SAT_L);
	localparam logic [OUT_W-1:0] CEIL_VAL  = OUT_W'(CEIL_SAT_L);

	// How a word leaves the divider chain.
	localparam int CODE_W = 3;
	localparam logic [CODE_W-1:0] CODE_DIV   = 3'd0;
	localparam logic [CODE_W-1:0] CODE_FAIL  = 3'd1;
	localparam logic [CODE_W-1:0] CODE_FLOOR = 3'd2;
	localparam logic [CODE_W-1:0] CODE_CEIL  = 3'd3;
	localparam logic [CODE_W-1:0] CODE_OVF   = 3'd4;

	typedef struct packed {
		logic [CFG_W-1:0] ped_low;
		logic [CFG_W-1:0] mip_peak;
		logic [CFG_W-1:0] ped_high;
		logic [CFG_W-1:0] slope;
		logic [CFG_W-1:0] sat;
	} p2m_cfg_t;

	// Word handed from one divider cell to the next. The low dividend bits
	// shift out at the top of lq while quotient bits shift in at the bottom.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [OUT_W-1:0]  lq;
		logic [DEN_W-1:0]  den;
		logic              neg;
		logic [CODE_W-1:0] code;
	} p2m_cell_t;

endpackage

// ===== sv/p2m_cfg_regs.sv =====
// Calibration register file behind the APB-style configuration port.
// Depends on p2m_pkg.
module p2m_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [p2m_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [p2m_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [p2m_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output p2m_pkg::p2m_cfg_t               cfg
);

	p2m_pkg::p2m_cfg_t                  cfg_q;
	logic [p2m_pkg::REG_IDX_W-1:0]      idx;
	logic [p2m_pkg::CFG_W-1:0]          wval;
	logic                               wr_en;
	logic [p2m_pkg::CFG_W-1:0]          rval;

	assign pready = 1'b1;
	assign idx    = paddr[p2m_pkg::APB_ADDR_W-1:2];
	assign wval   = pwdata[p2m_pkg::CFG_W-1:0];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				p2m_pkg::REG_PED_LOW:  cfg_q.ped_low  <= wval;
				p2m_pkg::REG_MIP_PEAK: cfg_q.mip_peak <= wval;
				p2m_pkg::REG_PED_HIGH: cfg_q.ped_high <= wval;
				p2m_pkg::REG_SLOPE:    cfg_q.slope    <= wval;
				p2m_pkg::REG_SAT:      cfg_q.sat      <= wval;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			p2m_pkg::REG_PED_LOW:  rval = cfg_q.ped_low;
			p2m_pkg::REG_MIP_PEAK: rval = cfg_q.mip_peak;
			p2m_pkg::REG_PED_HIGH: rval = cfg_q.ped_high;
			p2m_pkg::REG_SLOPE:    rval = cfg_q.slope;
			p2m_pkg::REG_SAT:      rval = cfg_q.sat;
			default:               rval = '0;
		endcase
	end

	assign prdata = p2m_pkg::APB_DATA_W'(rval);

endmodule

// ===== sv/p2m_front.sv =====
// Three front stages: pedestal subtraction and range checks, the two
// response products, then the ceiling and overflow checks. Depends on p2m_pkg.
module p2m_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  p2m_pkg::p2m_cfg_t              cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [p2m_pkg::PHA_BITS-1:0]   pulse_height,
	output logic                           out_valid,
	input  logic                           out_ready,
	output p2m_pkg::p2m_cell_t             out_data
);

	localparam int F = p2m_pkg::MIP_FRAC_BITS;

	// Stage handshake.
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	// Stage 1 logic and registers.
	logic [p2m_pkg::P_W-1:0]         p16;
	logic [p2m_pkg::CFG_W-1:0]       ped;
	logic signed [p2m_pkg::D_W:0]    d;
	logic [p2m_pkg::D_W-1:0]         mag;
	logic signed [p2m_pkg::D_W+1:0]  lim;
	logic                            near;
	logic [p2m_pkg::CODE_W-1:0]      code1;

	logic                            mode_s1;
	logic                            neg_s1;
	logic [p2m_pkg::D_W-1:0]         mag_s1;
	logic [p2m_pkg::CODE_W-1:0]      code_s1;

	// Stage 2 logic and registers.
	logic [p2m_pkg::CFG_W-1:0]       hd;
	logic [p2m_pkg::CFG_W-1:0]       hsub;
	logic [p2m_pkg::DEN_W-1:0]       top;
	logic [p2m_pkg::DEN_W-1:0]       bot;
	logic [p2m_pkg::NUM_W-1:0]       num;
	logic [p2m_pkg::DEN_W-1:0]       den;

	logic                            mode_s2;
	logic                            neg_s2;
	logic [p2m_pkg::NUM_W-1:0]       num_s2;
	logic [p2m_pkg::DEN_W-1:0]       den_s2;
	logic [p2m_pkg::CODE_W-1:0]      code_s2;

	// Stage 3 logic and register.
	logic [p2m_pkg::DEN_W-1:0]                     top3;
	logic [p2m_pkg::DEN_W+9:0]                     bot_k;
	logic                                          ceil_hit;
	logic [p2m_pkg::NUM_W-p2m_pkg::OUT_W-1:0]      hi_part;
	logic                                          ovf;
	p2m_pkg::p2m_cell_t                            word3;
	p2m_pkg::p2m_cell_t                            cell_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = v_s3;
	assign out_data  = cell_s3;

	always_comb begin
		p16  = {pulse_height, {p2m_pkg::CFG_FRAC{1'b0}}};
		ped  = mode ? cfg.ped_high : cfg.ped_low;
		d    = $signed({1'b0, p2m_pkg::D_W'(p16)}) - $signed({1'b0, p2m_pkg::D_W'(ped)});
		mag  = d[p2m_pkg::D_W] ? p2m_pkg::D_W'(-d) : d[p2m_pkg::D_W-1:0];
		// Saturation less margin is compared signed, so a small saturation
		// level catches every non-negative difference.
		lim  = $signed({2'b00, p2m_pkg::D_W'(cfg.sat)})
			- $signed((p2m_pkg::D_W+2)'(p2m_pkg::SAT_MARGIN));
		near = $signed({d[p2m_pkg::D_W], d}) > lim;
		if (!mode) begin
			code1 = (cfg.mip_peak == '0) ? p2m_pkg::CODE_FAIL : p2m_pkg::CODE_DIV;
		end else if (d[p2m_pkg::D_W]) begin
			code1 = p2m_pkg::CODE_FLOOR;
		end else if (near) begin
			code1 = p2m_pkg::CODE_CEIL;
		end else if (cfg.slope == '0) begin
			code1 = p2m_pkg::CODE_FAIL;
		end else begin
			code1 = p2m_pkg::CODE_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			mode_s1 <= mode;
			neg_s1  <= d[p2m_pkg::D_W] && !mode;
			mag_s1  <= mag;
			code_s1 <= code1;
		end
	end

	// In the high range a dividing sample sits below saturation, so its
	// difference fits the register width.
	always_comb begin
		hd   = mag_s1[p2m_pkg::CFG_W-1:0];
		hsub = cfg.sat - hd;
		top  = p2m_pkg::DEN_W'(cfg.sat) * p2m_pkg::DEN_W'(hd);
		bot  = p2m_pkg::DEN_W'(cfg.slope) * p2m_pkg::DEN_W'(hsub);
		num  = mode_s1 ? (p2m_pkg::NUM_W'(top) << F) : (p2m_pkg::NUM_W'(mag_s1) << F);
		den  = mode_s1 ? bot : p2m_pkg::DEN_W'(cfg.mip_peak);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			mode_s2 <= mode_s1;
			neg_s2  <= neg_s1;
			num_s2  <= num;
			den_s2  <= den;
			code_s2 <= code_s1;
		end
	end

	always_comb begin
		top3     = num_s2[p2m_pkg::NUM_W-1:F];
		bot_k    = (p2m_pkg::DEN_W+10)'(den_s2) * (p2m_pkg::DEN_W+10)'(p2m_pkg::CEIL_MIP);
		ceil_hit = (p2m_pkg::DEN_W+10)'(top3) > bot_k;
		hi_part  = num_s2[p2m_pkg::NUM_W-1:p2m_pkg::OUT_W];
		// A quotient that would not fit the output bits saturates directly.
		ovf      = p2m_pkg::NUM_W'(hi_part) >= p2m_pkg::NUM_W'(den_s2);
		word3.rem = p2m_pkg::REM_W'(hi_part);
		word3.lq  = num_s2[p2m_pkg::OUT_W-1:0];
		word3.den = den_s2;
		word3.neg = neg_s2;
		if (code_s2 != p2m_pkg::CODE_DIV) begin
			word3.code = code_s2;
		end else if (mode_s2 && ceil_hit) begin
			word3.code = p2m_pkg::CODE_CEIL;
		end else if (ovf) begin
			word3.code = p2m_pkg::CODE_OVF;
		end else begin
			word3.code = p2m_pkg::CODE_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			cell_s3 <= word3;
		end
	end

endmodule

// ===== sv/p2m_div_cell.sv =====
// One restoring division cell: develops one quotient bit per word.
// Depends on p2m_pkg.
module p2m_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  p2m_pkg::p2m_cell_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output p2m_pkg::p2m_cell_t  out_data
);

	logic                        valid_q;
	p2m_pkg::p2m_cell_t          data_q;
	p2m_pkg::p2m_cell_t          nxt;
	logic [p2m_pkg::REM_W:0]     t;
	logic [p2m_pkg::REM_W:0]     diff;
	logic                        ge;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		t        = {in_data.rem, in_data.lq[p2m_pkg::OUT_W-1]};
		ge       = t >= {1'b0, in_data.den};
		diff     = t - {1'b0, in_data.den};
		nxt      = in_data;
		nxt.rem  = ge ? diff[p2m_pkg::REM_W-1:0] : t[p2m_pkg::REM_W-1:0];
		nxt.lq   = {in_data.lq[p2m_pkg::OUT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== sv/p2m_out.sv =====
// Output register: applies the sign, the fixed results and saturation.
// Depends on p2m_pkg.
module p2m_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  p2m_pkg::p2m_cell_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [p2m_pkg::OUT_W-1:0]    mip_value,
	output logic                         failed,
	output logic                         clamped
);

	logic                          valid_q;
	logic [p2m_pkg::OUT_W-1:0]     value_q;
	logic                          failed_q;
	logic                          clamped_q;
	logic [p2m_pkg::OUT_W-1:0]     q;
	logic [p2m_pkg::OUT_W-1:0]     value;
	logic                          fl;
	logic                          cl;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign mip_value = value_q;
	assign failed    = failed_q;
	assign clamped   = clamped_q;

	always_comb begin
		q     = in_data.lq;
		value = '0;
		fl    = 1'b0;
		cl    = 1'b0;
		case (in_data.code)
			p2m_pkg::CODE_DIV: begin
				if (in_data.neg) begin
					// The most negative code is reachable exactly.
					if (q > p2m_pkg::OUT_MIN) begin
						value = p2m_pkg::OUT_MIN;
						cl    = 1'b1;
					end else begin
						value = -q;
					end
				end else if (q > p2m_pkg::OUT_MAX) begin
					value = p2m_pkg::OUT_MAX;
					cl    = 1'b1;
				end else begin
					value = q;
				end
			end
			p2m_pkg::CODE_OVF: begin
				value = in_data.neg ? p2m_pkg::OUT_MIN : p2m_pkg::OUT_MAX;
				cl    = 1'b1;
			end
			p2m_pkg::CODE_FAIL: begin
				fl = 1'b1;
			end
			p2m_pkg::CODE_FLOOR: begin
				value = p2m_pkg::FLOOR_VAL;
				cl    = 1'b1;
			end
			p2m_pkg::CODE_CEIL: begin
				value = p2m_pkg::CEIL_VAL;
				cl    = 1'b1;
			end
			default: begin
				value = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_q   <= value;
			failed_q  <= fl;
			clamped_q <= cl;
		end
	end

endmodule

// ===== sv/pha_to_mip_calibration.sv =====
// An accepted input word passes three front stages, one divider cell per
// quotient bit (19) and the output register on its way to the output.
// Throughput: one word per cycle while the consumer does not stall, set by the
// cell chain, which holds one word in every cell and moves them all on together.
// Reset clears the calibration registers to zero and empties every stage.
// Depends on p2m_pkg, p2m_cfg_regs, p2m_front, p2m_div_cell and p2m_out.
module pha_to_mip_calibration (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [p2m_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [p2m_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [p2m_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	// Input samples.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [p2m_pkg::IN_TDATA_W-1:0]      s_tdata,  // pulse_height, zero pad above
	input  logic [0:0]                          s_tuser,  // mode
	// Calibrated results.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [p2m_pkg::OUT_TDATA_W-1:0]     m_tdata,  // mip_value, zero pad above
	output logic [p2m_pkg::OUT_TUSER_W-1:0]     m_tuser   // failed, clamped
);

	localparam int N_CELLS = p2m_pkg::OUT_W;

	p2m_pkg::p2m_cfg_t     cfg;

	// Handshake and word at every link of the cell chain; link 0 is fed by
	// the front stages and link N_CELLS drives the output register.
	logic                  ch_valid [N_CELLS+1];
	logic                  ch_ready [N_CELLS+1];
	p2m_pkg::p2m_cell_t    ch_data  [N_CELLS+1];

	logic [p2m_pkg::OUT_W-1:0] mip_value;
	logic                      failed;
	logic                      clamped;

	p2m_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The front stages subtract the pedestal, sort out the range cases that
	// have a fixed answer, and form the dividend and divisor. The low range
	// divides the scaled difference by the MIP peak; the high range divides
	// saturation times difference by slope times remaining headroom.
	p2m_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.mode         (s_tuser[0]),
		.pulse_height (s_tdata[p2m_pkg::PHA_BITS-1:0]),
		.out_valid    (ch_valid[0]),
		.out_ready    (ch_ready[0]),
		.out_data     (ch_data[0])
	);

	// Each cell holds one word and produces one quotient bit, most
	// significant first. Words with a fixed answer ride along unchanged in
	// meaning, so the order of results always follows the order of samples.
	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		p2m_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (ch_valid[i]),
			.in_ready  (ch_ready[i]),
			.in_data   (ch_data[i]),
			.out_valid (ch_valid[i+1]),
			.out_ready (ch_ready[i+1]),
			.out_data  (ch_data[i+1])
		);
	end

	// The output register decouples the chain from the consumer: while a
	// finished word waits, words behind it keep moving into empty cells.
	p2m_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ch_valid[N_CELLS]),
		.in_ready  (ch_ready[N_CELLS]),
		.in_data   (ch_data[N_CELLS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.mip_value (mip_value),
		.failed    (failed),
		.clamped   (clamped)
	);

	assign m_tdata = p2m_pkg::OUT_TDATA_W'(mip_value);
	assign m_tuser = {clamped, failed};

endmodule

// ===== sim/tb_pha_to_mip_calibration.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pha_to_mip_calibration: stream stimulus with random
// idling on both sides, APB calibration writes and an in-bench integer predictor.
// Depends on p2m_pkg and the block itself.
module tb_pha_to_mip_calibration;
	import p2m_pkg::*;

	// Run length and pacing.
	localparam int LIMIT_CYCLES    = 500000;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_SAMPLES   = 240;
	localparam int HOLD_OFF_CYCLES = 800;
	localparam int DRAIN_CYCLES    = 40;
	localparam longint ONE_MIP     = longint'(1) << MIP_FRAC_BITS;

	// One input sample and one calibrated result word.
	typedef struct packed {
		logic                hi;
		logic [PHA_BITS-1:0] pha;
	} sample_t;

	typedef struct packed {
		logic [OUT_W-1:0] mip;
		logic             failed;
		logic             clamped;
	} mip_word_t;

	// Block ports. Every input starts at a known value.
	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr    = '0;
	logic [APB_DATA_W-1:0]  pwdata   = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;  // pulse_height, zero pad above
	logic [0:0]             s_tuser  = '0;  // mode
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // mip_value, zero pad above
	logic [OUT_TUSER_W-1:0] m_tuser;        // failed, clamped

	// The bench's copy of the calibration registers; reset leaves them all zero.
	logic [CFG_W-1:0] cal_ped_low  = '0;
	logic [CFG_W-1:0] cal_mip_peak = '0;
	logic [CFG_W-1:0] cal_ped_high = '0;
	logic [CFG_W-1:0] cal_slope    = '0;
	logic [CFG_W-1:0] cal_sat      = '0;

	// Samples waiting to be offered, and result words still owed by the block.
	sample_t   pending_samples[$];
	mip_word_t expected_words[$];

	// Handshake bookkeeping shared between the clocked processes.
	bit        in_taken   = 1'b0;
	bit        out_taken  = 1'b0;
	bit        send_calm  = 1'b0;
	bit        recv_calm  = 1'b1;
	int        send_gap   = 0;
	int        recv_gap   = 0;
	int        hold_off   = 0;
	sample_t   next_sample;
	mip_word_t want;

	// Statistics for the closing summary.
	int errors        = 0;
	int cycles        = 0;
	int samples_in    = 0;
	int words_out     = 0;
	int n_clamped     = 0;
	int n_failed      = 0;
	int settings_used = 0;

	pha_to_mip_calibration uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// Exact integer calibration of one sample against the current registers.
	// Low range divides the pedestal-corrected pulse by the MIP peak. High range
	// inverts the saturating curve sat*x/(slope*(sat-x)), with a floor below
	// the pedestal and a ceiling near saturation or for very large ratios.
	function automatic mip_word_t calib_predict(input logic hi,
			input logic [PHA_BITS-1:0] pha);
		longint    diff;
		longint    sat;
		longint    top;
		longint    bot;
		longint    val;
		mip_word_t res;
		res.failed  = 1'b0;
		res.clamped = 1'b0;
		val         = 0;
		if (!hi) begin
			diff = longint'(pha) * 16 - longint'(cal_ped_low);
			if (cal_mip_peak == '0) begin
				res.failed = 1'b1;
			end else begin
				// Signed division truncates toward zero, as the block must.
				val = (diff * ONE_MIP) / longint'(cal_mip_peak);
			end
		end else begin
			diff = longint'(pha) * 16 - longint'(cal_ped_high);
			sat  = longint'(cal_sat);
			if (diff < 0) begin
				val         = longint'(FLOOR_MIP) * ONE_MIP;
				res.clamped = 1'b1;
			end else if (diff > sat - SAT_MARGIN) begin
				// Signed compare: a saturation under 50 counts catches every sample.
				val         = longint'(CEIL_MIP) * ONE_MIP;
				res.clamped = 1'b1;
			end else if (cal_slope == '0) begin
				res.failed = 1'b1;
			end else begin
				top = sat * diff;
				bot = longint'(cal_slope) * (sat - diff);
				if (top > longint'(CEIL_MIP) * bot) begin
					val         = longint'(CEIL_MIP) * ONE_MIP;
					res.clamped = 1'b1;
				end else begin
					val = (top * ONE_MIP) / bot;
				end
			end
		end
		if (val > OUT_MAX_L) begin
			val         = OUT_MAX_L;
			res.clamped = 1'b1;
		end
		if (val < -OUT_MAX_L - 1) begin
			val         = -OUT_MAX_L - 1;
			res.clamped = 1'b1;
		end
		res.mip = val[OUT_W-1:0];
		return res;
	endfunction

	// One APB write: setup cycle, then access cycle. The register takes the value
	// at the rising edge inside the access cycle, since pready is always high.
	task automatic cal_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PED_LOW:  cal_ped_low  = value;
			REG_MIP_PEAK: cal_mip_peak = value;
			REG_PED_HIGH: cal_ped_high = value;
			REG_SLOPE:    cal_slope    = value;
			REG_SAT:      cal_sat      = value;
			default: ;
		endcase
	endtask

	// Writes the whole calibration set. It returns on a rising edge so that the
	// caller's next queue update never shares a time step with the driver.
	task automatic load_calibration(input logic [CFG_W-1:0] ped_low,
			input logic [CFG_W-1:0] mip_peak, input logic [CFG_W-1:0] ped_high,
			input logic [CFG_W-1:0] slope, input logic [CFG_W-1:0] sat);
		cal_write(REG_PED_LOW, ped_low);
		cal_write(REG_MIP_PEAK, mip_peak);
		cal_write(REG_PED_HIGH, ped_high);
		cal_write(REG_SLOPE, slope);
		cal_write(REG_SAT, sat);
		settings_used++;
		@(posedge clk);
	endtask

	task automatic offer_sample(input logic hi, input logic [PHA_BITS-1:0] pha);
		sample_t smp;
		smp.hi  = hi;
		smp.pha = pha;
		pending_samples.push_back(smp);
	endtask

	// Random samples, steered so that a good share lands near the pedestal or
	// inside the usable part of the high range curve, where the divisions live.
	task automatic random_samples(input int count);
		int   ped;
		int   level;
		logic hi;
		for (int i = 0; i < count; i++) begin
			hi  = 1'($urandom_range(0, 1));
			ped = hi ? int'(cal_ped_high) : int'(cal_ped_low);
			case ($urandom_range(0, 3))
				0: level = ped + int'($urandom_range(0, 3200)) - 1600;
				1: level = ped + int'($urandom_range(0, int'(cal_sat)));
				default: level = int'($urandom_range(0, 65535));
			endcase
			if (level < 0)
				level = 0;
			if (level > 65535)
				level = 65535;
			offer_sample(hi, PHA_BITS'(level >> CFG_FRAC));
		end
	endtask

	// Waits until every queued sample has been taken and every result word has
	// arrived. The sender stays paused meanwhile, so the block fully drains.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || s_tvalid || expected_words.size() != 0);
	endtask

	// Sender. Inputs move on the falling edge. A word on the bus is held until
	// the rising edge before has taken it; after each word a random idle gap
	// is drawn, with calm stretches where the gap is always zero.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					next_sample = pending_samples.pop_front();
					s_tdata     <= IN_TDATA_W'(next_sample.pha);
					s_tuser     <= next_sample.hi;
					s_tvalid    <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						send_calm = !send_calm;
					send_gap = send_calm ? 0 : $urandom_range(0, 14);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver. After each result word a random stall is drawn, again
	// with calm stretches. A long hold-off, when requested, is counted down
	// here one cycle at a time and overrides everything else.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_gap = recv_calm ? 0 : $urandom_range(0, 14);
			end
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor. On the rising edge it records both handshakes, predicts the
	// result of each accepted sample and checks each result word, field by
	// field, against the oldest prediction.
	always @(posedge clk) begin
		in_taken  = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (in_taken) begin
			expected_words.push_back(calib_predict(s_tuser[0], s_tdata[PHA_BITS-1:0]));
			samples_in++;
		end
		if (out_taken) begin
			words_out++;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected: mip_value %0d failed %b clamped %b",
					$time, $signed(m_tdata[OUT_W-1:0]), m_tuser[0], m_tuser[1]);
			end else begin
				want = expected_words.pop_front();
				n_clamped += want.clamped;
				n_failed  += want.failed;
				if (m_tdata[OUT_W-1:0] !== want.mip) begin
					errors++;
					$display("%0t: mip_value expected %0d got %0d", $time,
						$signed(want.mip), $signed(m_tdata[OUT_W-1:0]));
				end
				if (m_tuser[0] !== want.failed) begin
					errors++;
					$display("%0t: failed expected %b got %b", $time, want.failed, m_tuser[0]);
				end
				if (m_tuser[1] !== want.clamped) begin
					errors++;
					$display("%0t: clamped expected %b got %b", $time, want.clamped, m_tuser[1]);
				end
			end
		end
	end

	// Watchdog: a run that has not ended by now is stuck.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d result words still owed.",
				cycles, expected_words.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers straight out of reset are all zero: low range fails on the
		// zero MIP peak, high range hits the ceiling because saturation is zero.
		offer_sample(1'b0, 12'd0);
		offer_sample(1'b0, 12'd4095);
		offer_sample(1'b1, 12'd0);
		offer_sample(1'b1, 12'd4095);
		wait_drained();

		// Typical calibration: pedestals of 100 and 200 counts, 40 counts per
		// MIP, slope of 10 counts, saturation at 3000 counts.
		load_calibration(16'd1600, 16'd640, 16'd3200, 16'd160, 16'd48000);
		offer_sample(1'b0, 12'd50);    // below the low pedestal, negative value
		offer_sample(1'b0, 12'd100);   // exactly on the pedestal
		offer_sample(1'b0, 12'd4095);
		offer_sample(1'b1, 12'd150);   // below the high pedestal, floor
		offer_sample(1'b1, 12'd200);   // on the pedestal, zero signal
		offer_sample(1'b1, 12'd400);   // plain inversion of the curve
		offer_sample(1'b1, 12'd3150);  // last point before the margin, ratio ceiling
		offer_sample(1'b1, 12'd3151);  // first point inside the margin
		wait_drained();

		// Huge low pedestal with unit gain drives the low range into negative
		// saturation; a zero slope fails only once the division is reached.
		load_calibration(16'hFFFF, 16'd1, 16'd0, 16'd0, 16'hFFFF);
		offer_sample(1'b0, 12'd0);
		offer_sample(1'b0, 12'd4095);
		offer_sample(1'b1, 12'd100);
		offer_sample(1'b1, 12'd4095);
		wait_drained();

		// Every register at its maximum.
		load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		offer_sample(1'b0, 12'd0);
		offer_sample(1'b0, 12'd4095);
		offer_sample(1'b1, 12'd4095);
		wait_drained();

		// Unit gains with zero pedestals: positive saturation in the low range,
		// and the high range from zero signal up to the ratio ceiling.
		load_calibration(16'd0, 16'd1, 16'd0, 16'd1, 16'hFFFF);
		offer_sample(1'b0, 12'd4095);
		offer_sample(1'b1, 12'd0);
		offer_sample(1'b1, 12'd1);
		offer_sample(1'b1, 12'd100);
		wait_drained();

		// Random phases, each under its own calibration and each ending with the
		// sender paused until the block has handed back every result word.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				2: load_calibration(CFG_W'($urandom_range(0, 6400)),
					CFG_W'($urandom_range(16, 3200)), CFG_W'($urandom_range(0, 6400)),
					CFG_W'($urandom_range(1, 800)), CFG_W'($urandom_range(0, 799)));
				3: load_calibration(CFG_W'($urandom_range(0, 6400)), 16'd0,
					CFG_W'($urandom_range(0, 6400)), 16'd0,
					CFG_W'($urandom_range(16000, 65535)));
				4, 7: load_calibration(CFG_W'($urandom_range(0, 65535)),
					CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
					CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
				5: load_calibration(CFG_W'($urandom_range(0, 6400)),
					CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(0, 6400)),
					CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(16000, 65535)));
				default: load_calibration(CFG_W'($urandom_range(0, 6400)),
					CFG_W'($urandom_range(16, 3200)), CFG_W'($urandom_range(0, 6400)),
					CFG_W'($urandom_range(1, 800)), CFG_W'($urandom_range(16000, 65535)));
			endcase
			// In one phase the receiver stops for a long while as the sender keeps
			// offering words, so the pipeline fills and s_tready has to drop.
			if (phase == 1)
				hold_off = HOLD_OFF_CYCLES;
			random_samples(PHASE_SAMPLES);
			wait_drained();
		end

		// Give a stray extra word time to show up before closing.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d samples in both ranges over %0d register settings,",
			samples_in, settings_used);
		$display("with %0d result words checked (%0d clamped, %0d failed).",
			words_out, n_clamped, n_failed);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== pha_to_mip_calibration.f =====
sv/p2m_pkg.sv
sv/p2m_cfg_regs.sv
sv/p2m_front.sv
sv/p2m_div_cell.sv
sv/p2m_out.sv
sv/pha_to_mip_calibration.sv
sim/tb_pha_to_mip_calibration.sv
